@@ rtl/core/moving_average_warmup_defines.svh @@
// Assertion helpers used by the moving average RTL.
`ifndef MOVING_AVERAGE_WARMUP_DEFINES_SVH
`define MOVING_AVERAGE_WARMUP_DEFINES_SVH

// Checks cons in the same cycle as ante, outside reset.
`define MAVW_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Checks cons in the cycle after ante, outside reset.
`define MAVW_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/core/mavw_pkg.sv @@
`timescale 1ns / 1ps

package mavw_pkg;

  // Fixed field widths of the ports.
  localparam int CNT_W = 7;
  localparam int IN_W  = 32;
  localparam int OUT_W = 32;

  // Window length after reset.
  localparam int WIN_RESET = 10;

endpackage

@@ rtl/core/moving_average_warmup.sv @@
`timescale 1ns / 1ps
// Channel   | Handshake              | Payload
// ----------+------------------------+-----------------------------------
// cfg       | cfg_valid / cfg_ready  | window_len
// input     | in_valid / in_stall    | sample, first_sample
// output    | out_valid / out_stall  | average, samples_used
//
// Each transaction reads the ring, updates the running sum, computes the quotient bit by bit
// in the bit-serial restoring divider, and then loads the output register.
// A new transaction is taken once the previous quotient sits in the output register,
// even while that result is stalled; a stalled result holds back the next quotient.
// Reset clears control state, the sum and the counters; the ring is written before read.

`include "moving_average_warmup_defines.svh"

module moving_average_warmup #(
  parameter int MAX_WINDOW  = 64,
  parameter int SAMPLE_BITS = 32
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [mavw_pkg::CNT_W-1:0] window_len,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic [mavw_pkg::IN_W-1:0] sample,
  input  logic                      first_sample,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic [mavw_pkg::OUT_W-1:0] average,
  output logic [mavw_pkg::CNT_W-1:0] samples_used
);

  localparam int CNT_W    = mavw_pkg::CNT_W;
  localparam int PTR_W    = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
  localparam int SUM_W    = SAMPLE_BITS + CNT_W;
  localparam int DCNT_W   = $clog2(SUM_W);
  localparam int CNT_MAX  = (1 << CNT_W) - 1;
  localparam int WIN_CAP  = (MAX_WINDOW < CNT_MAX) ? MAX_WINDOW : CNT_MAX;
  localparam int WIN_INIT = (mavw_pkg::WIN_RESET < WIN_CAP) ? mavw_pkg::WIN_RESET : WIN_CAP;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SUM,
    S_DIV,
    S_DONE
  } state_t;

  state_t                   state;
  logic [CNT_W-1:0]         window_cfg;
  logic [CNT_W-1:0]         active_window;
  logic [PTR_W-1:0]         write_pointer;
  logic [CNT_W-1:0]         fill_count;
  logic [SUM_W-1:0]         running_sum;
  logic [SAMPLE_BITS-1:0]   smp_q;
  logic                     full_q;
  logic [SAMPLE_BITS-1:0]   old_q;
  logic [SAMPLE_BITS-1:0]   ring [MAX_WINDOW];
  logic [SUM_W-1:0]         div_sr;
  logic [CNT_W-1:0]         div_rem;
  logic [DCNT_W-1:0]        div_cnt;

  logic                     accept;
  logic [SAMPLE_BITS-1:0]   smp;
  logic [CNT_W-1:0]         win_clamped;
  logic [CNT_W-1:0]         eff_aw;
  logic [PTR_W-1:0]         eff_wp;
  logic [CNT_W-1:0]         eff_fill;
  logic [PTR_W-1:0]         idx;
  logic                     win_full;
  logic [CNT_W-1:0]         fill_next;
  logic [PTR_W-1:0]         write_pointer_next;
  logic [SUM_W-1:0]         sum_next;
  logic [CNT_W:0]           trial;
  logic                     trial_ge;
  logic [CNT_W-1:0]         div_rem_next;

  assign cfg_ready = 1'b1;
  assign in_stall  = (state != S_IDLE);
  assign accept    = in_valid && !in_stall;
  assign smp       = SAMPLE_BITS'(sample);

  always_comb begin
    if (window_cfg == '0) begin
      win_clamped = CNT_W'(1);
    end else if (int'(window_cfg) > WIN_CAP) begin
      win_clamped = CNT_W'(WIN_CAP);
    end else begin
      win_clamped = window_cfg;
    end
  end

  // A new series starts from an empty history with the latched window.
  always_comb begin
    eff_aw   = first_sample ? win_clamped : active_window;
    eff_wp   = first_sample ? '0 : write_pointer;
    eff_fill = first_sample ? '0 : fill_count;
    idx      = (int'(eff_wp) >= int'(eff_aw)) ? '0 : eff_wp;
    win_full = (eff_fill >= eff_aw);
    fill_next = win_full ? eff_fill : eff_fill + 1'b1;
    write_pointer_next = (int'(idx) + 1 >= int'(eff_aw)) ? '0 : idx + 1'b1;
  end

  // Once the window is full, the slot being overwritten holds the oldest sample.
  assign sum_next = running_sum - (full_q ? SUM_W'(old_q) : '0) + SUM_W'(smp_q);

  // One restoring step: the remainder stays below the divisor, so it fits CNT_W bits.
  always_comb begin
    trial        = {div_rem, div_sr[SUM_W-1]};
    trial_ge     = (trial >= {1'b0, fill_count});
    div_rem_next = trial_ge ? CNT_W'(trial - {1'b0, fill_count}) : CNT_W'(trial);
  end

  // Read-first ring: the old entry comes out while the new sample goes in.
  always_ff @(posedge clk) begin
    if (accept) begin
      old_q     <= ring[idx];
      ring[idx] <= smp;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      out_valid     <= 1'b0;
      window_cfg    <= CNT_W'(mavw_pkg::WIN_RESET);
      active_window <= CNT_W'(WIN_INIT);
      write_pointer <= '0;
      fill_count    <= '0;
      running_sum   <= '0;
    end else begin
      if (cfg_valid) begin
        window_cfg <= window_len;
      end
      // In S_DONE the output register is reloaded instead of cleared.
      if (out_valid && !out_stall && state != S_DONE) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (accept) begin
            active_window <= eff_aw;
            write_pointer <= write_pointer_next;
            fill_count    <= fill_next;
            running_sum   <= first_sample ? '0 : running_sum;
            smp_q         <= smp;
            full_q        <= win_full;
            state         <= S_SUM;
          end
        end
        S_SUM: begin
          running_sum <= sum_next;
          div_sr      <= sum_next;
          div_rem     <= '0;
          div_cnt     <= DCNT_W'(SUM_W - 1);
          state       <= S_DIV;
        end
        S_DIV: begin
          div_sr  <= {div_sr[SUM_W-2:0], trial_ge};
          div_rem <= div_rem_next;
          if (div_cnt == '0) begin
            state <= S_DONE;
          end else begin
            div_cnt <= div_cnt - 1'b1;
          end
        end
        S_DONE: begin
          if (!out_valid || !out_stall) begin
            out_valid    <= 1'b1;
            average      <= mavw_pkg::OUT_W'(div_sr);
            samples_used <= fill_count;
            state        <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  `MAVW_ASSERT_NEXT(a_accept_starts_sum, accept, state == S_SUM, "accept did not start the sum")
  `MAVW_ASSERT_NOW(a_rem_below_divisor, state == S_DIV, div_rem < fill_count, "remainder too large")
  `MAVW_ASSERT_NOW(a_fill_range, 1'b1, fill_count <= active_window, "fill count too large")
  `MAVW_ASSERT_NOW(a_ptr_range, 1'b1, int'(write_pointer) < int'(active_window), "pointer range")
  `MAVW_ASSERT_NOW(a_result_from_done, $rose(out_valid), $past(state == S_DONE), "early result")

endmodule
